### rtl/plpsd_pkg.sv
// ----------------------------------------------------------------------------
// plpsd_pkg
// Shared types, codes and reset values for the power LED status detector.
// ----------------------------------------------------------------------------
package plpsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [2:0] REG_GLITCH   = 3'd0;
  localparam logic [2:0] REG_LONG     = 3'd1;
  localparam logic [2:0] REG_CONFIRM  = 3'd2;
  localparam logic [2:0] REG_PERIODIC = 3'd3;
  localparam logic [2:0] REG_SLEEP    = 3'd4;

  localparam logic [15:0] RST_GLITCH_MS   = 16'd50;
  localparam logic [31:0] RST_LONG_MS     = 32'd2000;
  localparam logic [31:0] RST_CONFIRM_MS  = 32'd6000;
  localparam logic [31:0] RST_PERIODIC_MS = 32'd300000;
  localparam logic [3:0]  RST_SLEEP_LIMIT = 4'd5;

  localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
  localparam logic [1:0] FUNC_SET_ON     = 2'd1;
  localparam logic [1:0] FUNC_SET_OFF    = 2'd2;
  localparam logic [1:0] FUNC_LONG_PRESS = 2'd3;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_SET_ON,
    CMD_SET_OFF,
    CMD_LONG_PRESS
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UNDEF   = 3'd0,
    ST_OFF     = 3'd1,
    ST_ON      = 3'd2,
    ST_SLEEP   = 3'd3,
    ST_PWR_ON  = 3'd4,
    ST_PWR_OFF = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PUSH_NONE  = 2'd0,
    PUSH_SHORT = 2'd1,
    PUSH_LONG  = 2'd2
  } push_t;

  typedef struct packed {
    logic [15:0] glitch_ms;
    logic [31:0] long_ms;
    logic [31:0] confirm_ms;
    logic [31:0] periodic_ms;
    logic [3:0]  sleep_limit;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       changed;
    logic [2:0] prev;
    logic [1:0] push;
  } res_t;

endpackage

### rtl/power_led_pulse_status_detector.sv
// ----------------------------------------------------------------------------
// power_led_pulse_status_detector
// Power state tracker driven by power-LED samples and power-button commands.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle while in_full is low and
// returns exactly one result transaction for each, in order. A transaction
// passes from the input queue through the back end into the result queue; the
// rate is set by the update of the power state in the back end, and both sides
// are decoupled by queues of FIFO_DEPTH entries; either side may stall, until
// the queues fill, without stopping the other. The user must write thresholds
// over the APB port only while no transaction is in flight; it is not enforced.
module power_led_pulse_status_detector
  import plpsd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_func,
  input  logic                  in_led_level,
  input  logic [31:0]           in_now_ms,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [2:0]            out_status,
  output logic                  out_status_changed,
  output logic [2:0]            out_previous_status,
  output logic [1:0]            out_push_request,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg;
  item_t item;
  logic  item_empty;
  logic  item_pop;
  res_t  res;

  plpsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plpsd_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_func      (in_func),
    .in_led_level (in_led_level),
    .in_now_ms    (in_now_ms),
    .in_full      (in_full),
    .item_pop     (item_pop),
    .item         (item),
    .item_empty   (item_empty)
  );

  plpsd_back #(
    .DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .out_pop    (out_pop),
    .res        (res),
    .out_empty  (out_empty)
  );

  assign out_status          = res.status;
  assign out_status_changed  = res.changed;
  assign out_previous_status = res.prev;
  assign out_push_request    = res.push;

endmodule

### rtl/plpsd_fifo.sv
// ----------------------------------------------------------------------------
// plpsd_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module plpsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/plpsd_cfg.sv
// ----------------------------------------------------------------------------
// plpsd_cfg
// APB-style register file holding the detector thresholds.
// ----------------------------------------------------------------------------
module plpsd_cfg
  import plpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glitch_ms   <= RST_GLITCH_MS;
      cfg_r.long_ms     <= RST_LONG_MS;
      cfg_r.confirm_ms  <= RST_CONFIRM_MS;
      cfg_r.periodic_ms <= RST_PERIODIC_MS;
      cfg_r.sleep_limit <= RST_SLEEP_LIMIT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GLITCH:   cfg_r.glitch_ms   <= pwdata[15:0];
        REG_LONG:     cfg_r.long_ms     <= pwdata;
        REG_CONFIRM:  cfg_r.confirm_ms  <= pwdata;
        REG_PERIODIC: cfg_r.periodic_ms <= pwdata;
        REG_SLEEP:    cfg_r.sleep_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GLITCH:   prdata = {16'd0, cfg_r.glitch_ms};
      REG_LONG:     prdata = cfg_r.long_ms;
      REG_CONFIRM:  prdata = cfg_r.confirm_ms;
      REG_PERIODIC: prdata = cfg_r.periodic_ms;
      REG_SLEEP:    prdata = {28'd0, cfg_r.sleep_limit};
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/plpsd_front.sv
// ----------------------------------------------------------------------------
// plpsd_front
// Accepts input transactions, decodes the function code and queues them.
// ----------------------------------------------------------------------------
module plpsd_front
  import plpsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [1:0]  in_func,
  input  logic        in_led_level,
  input  logic [31:0] in_now_ms,
  output logic        in_full,
  input  logic        item_pop,
  output item_t       item,
  output logic        item_empty
);

  item_t                 wr_item;
  logic [$bits(item_t)-1:0] rd_bits;

  always_comb begin
    case (in_func)
      FUNC_SAMPLE:     wr_item.cmd = CMD_SAMPLE;
      FUNC_SET_ON:     wr_item.cmd = CMD_SET_ON;
      FUNC_SET_OFF:    wr_item.cmd = CMD_SET_OFF;
      FUNC_LONG_PRESS: wr_item.cmd = CMD_LONG_PRESS;
      default:         wr_item.cmd = CMD_SAMPLE;
    endcase
    wr_item.level  = in_led_level;
    wr_item.now_ms = in_now_ms;
  end

  plpsd_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (wr_item),
    .full  (in_full),
    .pop   (item_pop),
    .rdata (rd_bits),
    .empty (item_empty)
  );

  assign item = item_t'(rd_bits);

endmodule

### rtl/plpsd_back.sv
// ----------------------------------------------------------------------------
// plpsd_back
// Executes queued transactions against the power state and queues results.
// ----------------------------------------------------------------------------
module plpsd_back
  import plpsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  item_empty,
  output logic  item_pop,
  input  logic  out_pop,
  output res_t  res,
  output logic  out_empty
);

  status_t     state_r, state_nxt;
  logic        last_level_r, last_level_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  logic [31:0] last_check_r, last_check_nxt;
  logic [3:0]  short_r, short_nxt;
  logic [7:0]  long_r, long_nxt;
  logic [7:0]  pending_r, pending_nxt;

  logic        res_full;
  logic        proc;
  res_t        res_w;
  logic [$bits(res_t)-1:0] res_bits;
  logic [31:0] since;
  logic [31:0] since_after;
  logic [31:0] idle;
  logic        edge_hit;
  logic        confirm;
  status_t     level_status;
  push_t       push_code;

  assign proc     = !item_empty && !res_full;
  assign item_pop = proc;

  always_comb begin
    state_nxt      = state_r;
    last_level_nxt = last_level_r;
    last_edge_nxt  = last_edge_r;
    last_check_nxt = last_check_r;
    short_nxt      = short_r;
    long_nxt       = long_r;
    pending_nxt    = pending_r;
    push_code      = PUSH_NONE;
    confirm        = 1'b0;
    since          = item.now_ms - last_edge_r;
    idle           = item.now_ms - last_check_r;
    edge_hit       = (item.level != last_level_r) && (since > {16'd0, cfg.glitch_ms});
    since_after    = edge_hit ? '0 : since;
    level_status   = item.level ? ST_OFF : ST_ON;

    case (item.cmd)
      CMD_SAMPLE: begin
        if (edge_hit) begin
          if (since > cfg.long_ms) begin
            long_nxt = (long_r == '1) ? long_r : long_r + 1'b1;
          end else begin
            short_nxt = (short_r == '1) ? short_r : short_r + 1'b1;
          end
          last_edge_nxt  = item.now_ms;
          last_level_nxt = item.level;
          pending_nxt    = (pending_r == '1) ? pending_r : pending_r + 1'b1;
        end
        if (pending_nxt != '0) begin
          if (short_nxt > cfg.sleep_limit) begin
            state_nxt      = ST_SLEEP;
            short_nxt      = '0;
            long_nxt       = '0;
            pending_nxt    = '0;
            last_check_nxt = item.now_ms;
          end
          if (long_nxt != '0 && since_after > cfg.confirm_ms) begin
            long_nxt    = '0;
            pending_nxt = '0;
            confirm     = 1'b1;
          end
        end else if (idle > cfg.periodic_ms && state_r != ST_SLEEP) begin
          confirm = 1'b1;
        end
        if (confirm) begin
          last_check_nxt = item.now_ms;
          state_nxt      = level_status;
        end
      end
      CMD_SET_ON: begin
        if (state_r inside {ST_OFF, ST_SLEEP, ST_UNDEF}) begin
          push_code = PUSH_SHORT;
          if (state_r == ST_SLEEP) begin
            pending_nxt    = '0;
            short_nxt      = '0;
            last_level_nxt = 1'b1;
            last_edge_nxt  = item.now_ms - cfg.long_ms;
          end
          state_nxt      = ST_PWR_ON;
          last_check_nxt = item.now_ms;
        end
      end
      CMD_SET_OFF: begin
        if (state_r == ST_ON) begin
          push_code      = PUSH_SHORT;
          state_nxt      = ST_PWR_OFF;
          last_check_nxt = item.now_ms;
        end
      end
      CMD_LONG_PRESS: begin
        case (state_r)
          ST_OFF:  state_nxt = ST_PWR_ON;
          ST_ON:   state_nxt = ST_PWR_OFF;
          default: state_nxt = ST_UNDEF;
        endcase
        push_code      = PUSH_LONG;
        last_check_nxt = item.now_ms;
      end
      default: ;
    endcase

    res_w.status  = state_nxt;
    res_w.changed = (state_nxt != state_r);
    res_w.prev    = state_r;
    res_w.push    = push_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_UNDEF;
      last_level_r <= 1'b1;
      last_edge_r  <= '0;
      last_check_r <= '0;
      short_r      <= '0;
      long_r       <= '0;
      pending_r    <= '0;
    end else if (proc) begin
      state_r      <= state_nxt;
      last_level_r <= last_level_nxt;
      last_edge_r  <= last_edge_nxt;
      last_check_r <= last_check_nxt;
      short_r      <= short_nxt;
      long_r       <= long_nxt;
      pending_r    <= pending_nxt;
    end
  end

  plpsd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (proc),
    .wdata (res_w),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res = res_t'(res_bits);

  a_changed_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (res_w.changed == (res_w.status != res_w.prev)))
    else $error("status_changed disagrees with status and previous status");

  a_long_push_only_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> ((res_w.push == PUSH_LONG) == (item.cmd == CMD_LONG_PRESS)))
    else $error("long push request without a long press command");

  a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (state_r == $past(res_w.status)))
    else $error("power state register does not match the reported status");

endmodule

### dv/plpsd_status_monitor.sv
// ----------------------------------------------------------------------------
// plpsd_status_monitor
// Watches the input, result and register ports of the power LED status
// detector, predicts the result of every accepted input transaction from its
// own copy of the thresholds and tracking state, and compares each accepted
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module plpsd_status_monitor
  import plpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [1:0]            in_func,
  input  logic                  in_led_level,
  input  logic [31:0]           in_now_ms,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [2:0]            out_status,
  input  logic                  out_status_changed,
  input  logic [2:0]            out_previous_status,
  input  logic [1:0]            out_push_request,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int unsigned           mismatches,
  output int unsigned           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        thresholds;
  status_t     pwr;
  logic        last_lvl;
  logic [31:0] t_edge;
  logic [31:0] t_check;
  logic [3:0]  n_short;
  logic [7:0]  n_long;
  logic [7:0]  n_pend;
  logic        chg;
  res_t        expected_status_q[$];
  res_t        want;
  res_t        got;
  int unsigned n_bad = 0;

  task automatic move_to(input status_t nxt);
    if (pwr != nxt) begin
      pwr = nxt;
      chg = 1'b1;
    end
  endtask

  task automatic track_power(input cmd_t cmd, input logic lvl, input logic [31:0] now,
                             output res_t r);
    logic [31:0] since;
    logic [31:0] idle_ms;
    logic        confirm;
    push_t       push;
    r.prev  = pwr;
    chg     = 1'b0;
    confirm = 1'b0;
    push    = PUSH_NONE;
    case (cmd)
      CMD_SAMPLE: begin
        since = now - t_edge;
        if (lvl != last_lvl && since > {16'd0, thresholds.glitch_ms}) begin
          if (since > thresholds.long_ms) begin
            if (n_long != 8'hFF) n_long++;
          end else if (n_short != 4'hF) begin
            n_short++;
          end
          t_edge   = now;
          last_lvl = lvl;
          if (n_pend != 8'hFF) n_pend++;
        end
        since   = now - t_edge;
        idle_ms = now - t_check;
        if (n_pend != 8'd0) begin
          if (n_short > thresholds.sleep_limit) begin
            move_to(ST_SLEEP);
            n_short = '0;
            n_long  = '0;
            n_pend  = '0;
            t_check = now;
          end
          if (n_long != 8'd0 && since > thresholds.confirm_ms) begin
            n_long  = '0;
            n_pend  = '0;
            confirm = 1'b1;
          end
        end else if (idle_ms > thresholds.periodic_ms && pwr != ST_SLEEP) begin
          confirm = 1'b1;
        end
        if (confirm) begin
          t_check = now;
          move_to(lvl ? ST_OFF : ST_ON);
        end
      end
      CMD_SET_ON: begin
        if (pwr == ST_OFF || pwr == ST_SLEEP || pwr == ST_UNDEF) begin
          push = PUSH_SHORT;
          // Waking from sleep restarts the edge tracking.
          if (pwr == ST_SLEEP) begin
            n_pend   = '0;
            n_short  = '0;
            last_lvl = 1'b1;
            t_edge   = now - thresholds.long_ms;
          end
          move_to(ST_PWR_ON);
          t_check = now;
        end
      end
      CMD_SET_OFF: begin
        if (pwr == ST_ON) begin
          push = PUSH_SHORT;
          move_to(ST_PWR_OFF);
          t_check = now;
        end
      end
      default: begin
        if (pwr == ST_OFF) move_to(ST_PWR_ON);
        else if (pwr == ST_ON) move_to(ST_PWR_OFF);
        else move_to(ST_UNDEF);
        push    = PUSH_LONG;
        t_check = now;
      end
    endcase
    r.status  = pwr;
    r.changed = chg;
    r.push    = push;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thresholds.glitch_ms   = RST_GLITCH_MS;
      thresholds.long_ms     = RST_LONG_MS;
      thresholds.confirm_ms  = RST_CONFIRM_MS;
      thresholds.periodic_ms = RST_PERIODIC_MS;
      thresholds.sleep_limit = RST_SLEEP_LIMIT;
      pwr      = ST_UNDEF;
      last_lvl = 1'b1;
      t_edge   = '0;
      t_check  = '0;
      n_short  = '0;
      n_long   = '0;
      n_pend   = '0;
      expected_status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_GLITCH:   thresholds.glitch_ms   = pwdata[15:0];
          REG_LONG:     thresholds.long_ms     = pwdata;
          REG_CONFIRM:  thresholds.confirm_ms  = pwdata;
          REG_PERIODIC: thresholds.periodic_ms = pwdata;
          REG_SLEEP:    thresholds.sleep_limit = pwdata[3:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        track_power(cmd_t'(in_func), in_led_level, in_now_ms, want);
        expected_status_q.push_back(want);
      end
      if (!out_empty && out_pop) begin
        got.status  = out_status;
        got.changed = out_status_changed;
        got.prev    = out_previous_status;
        got.push    = out_push_request;
        if (expected_status_q.size() == 0) begin
          if (n_bad < 200)
            $display("%0t: result transaction with no prediction waiting, status %0d",
                     $realtime, got.status);
          n_bad++;
        end else begin
          want = expected_status_q.pop_front();
          if (got !== want) begin
            if (n_bad < 200)
              $display({"%0t: expected status %0d changed %0d previous %0d push %0d, ",
                        "actual status %0d changed %0d previous %0d push %0d"},
                       $realtime, want.status, want.changed, want.prev, want.push,
                       got.status, got.changed, got.prev, got.push);
            n_bad++;
          end
        end
      end
    end
    mismatches      <= n_bad;
    results_pending <= expected_status_q.size();
  end

endmodule

### dv/power_led_pulse_status_detector_test.sv
// ----------------------------------------------------------------------------
// power_led_pulse_status_detector_test
// Drives LED samples and power-button commands into the power LED status
// detector through its input queue, with random stalls on both sides, and
// reprograms the thresholds between phases, extremes included. A directed
// sequence walks through confirmation, periodic recheck, sleep and wake;
// random phases follow. The monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module power_led_pulse_status_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plpsd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [1:0]            in_func = FUNC_SAMPLE;
  logic                  in_led_level = 1'b0;
  logic [31:0]           in_now_ms = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [2:0]            out_status;
  logic                  out_status_changed;
  logic [2:0]            out_previous_status;
  logic [1:0]            out_push_request;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int unsigned           mismatches;
  int unsigned           results_pending;

  int unsigned stall_cycles = 0;
  logic        steady = 1'b0;
  logic [31:0] t_now = '0;
  logic        lvl_now = 1'b0;
  logic [31:0] glitch_ms = {16'd0, RST_GLITCH_MS};
  logic [31:0] long_ms = RST_LONG_MS;
  logic [31:0] confirm_ms = RST_CONFIRM_MS;
  logic [31:0] periodic_ms = RST_PERIODIC_MS;

  always #5 clk = ~clk;

  power_led_pulse_status_detector i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_led_level       (in_led_level),
    .in_now_ms          (in_now_ms),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_status_changed (out_status_changed),
    .out_previous_status(out_previous_status),
    .out_push_request   (out_push_request),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  plpsd_status_monitor i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_led_level       (in_led_level),
    .in_now_ms          (in_now_ms),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_status_changed (out_status_changed),
    .out_previous_status(out_previous_status),
    .out_push_request   (out_push_request),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .mismatches         (mismatches),
    .results_pending    (results_pending)
  );

  always @(posedge clk) begin
    if ((in_push && !in_full) || (!out_empty && out_pop)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send(input cmd_t cmd, input logic lvl, input logic [31:0] stamp);
    in_push      <= 1'b1;
    in_func      <= cmd;
    in_led_level <= lvl;
    in_now_ms    <= stamp;
    do @(posedge clk); while (in_full);
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [15:0] g, input logic [31:0] l,
                                    input logic [31:0] c, input logic [31:0] p,
                                    input logic [3:0] s);
    drain();
    write_reg(REG_GLITCH, {16'd0, g});
    write_reg(REG_LONG, l);
    write_reg(REG_CONFIRM, c);
    write_reg(REG_PERIODIC, p);
    write_reg(REG_SLEEP, {28'd0, s});
    glitch_ms   = {16'd0, g};
    long_ms     = l;
    confirm_ms  = c;
    periodic_ms = p;
  endtask

  // Time steps cluster around the current thresholds so that glitches, short
  // and long edges, quiet confirmation and periodic rechecks all occur.
  task automatic random_item(input int unsigned toggle_pct);
    logic [31:0] dt;
    cmd_t        cmd;
    logic        lvl;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: dt = $urandom_range(0, glitch_ms + 20);
      4, 5:       dt = $urandom_range(0, long_ms);
      6:          dt = long_ms + $urandom_range(1, 100);
      7:          dt = confirm_ms + $urandom_range(1, 100);
      8:          dt = periodic_ms + $urandom_range(0, 10);
      default:    dt = $urandom();
    endcase
    t_now = t_now + dt;
    if ($urandom_range(0, 99) < 15) begin
      cmd = cmd_t'($urandom_range(1, 3));
      lvl = 1'($urandom_range(0, 1));
    end else begin
      cmd     = CMD_SAMPLE;
      lvl     = ($urandom_range(0, 99) < toggle_pct) ? ~lvl_now : lvl_now;
      lvl_now = lvl;
    end
    send(cmd, lvl, t_now);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send(CMD_SAMPLE, 1'b0, 32'd0);
    send(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
    send(CMD_SAMPLE, 1'b0, 32'd6999);
    send(CMD_SET_OFF, 1'b1, 32'd7001);
    send(CMD_SET_OFF, 1'b0, 32'd7002);
    send(CMD_SAMPLE, 1'b1, 32'd9100);
    send(CMD_SAMPLE, 1'b1, 32'd15200);
    send(CMD_LONG_PRESS, 1'b0, 32'd15300);
    send(CMD_LONG_PRESS, 1'b1, 32'd15400);
    send(CMD_SET_ON, 1'b1, 32'd15500);
    send(CMD_SAMPLE, 1'b1, 32'd400000);
    send(CMD_LONG_PRESS, 1'b1, 32'd400100);
    for (int k = 0; k < 7; k++) send(CMD_SAMPLE, k[0], 32'd400200 + 32'd100 * k);
    send(CMD_SAMPLE, 1'b1, 32'd400820);
    send(CMD_SAMPLE, 1'b0, 32'd700900);
    send(CMD_SET_ON, 1'b0, 32'd700950);
    send(CMD_SAMPLE, 1'b0, 32'd700960);
    send(CMD_SAMPLE, 1'b0, 32'd707000);
    send(CMD_LONG_PRESS, 1'b0, 32'd707100);
    send(CMD_SET_ON, 1'b1, 32'd707200);

    t_now = 32'd707200;
    repeat (170) random_item(60);

    program_thresholds(16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    repeat (320) random_item(90);

    program_thresholds(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 4'd15);
    repeat (130) random_item(70);

    program_thresholds(16'd10, 32'd100, 32'd300, 32'd1000, 4'd2);
    repeat (60) random_item(60);
    drain();
    repeat (40) random_item(60);
    steady = 1'b1;
    repeat (100) random_item(60);

    drain();
    if (mismatches == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
